// File: hw/rtl/pvf_pkg.sv
// Shared types and constants of the PE section address translator.
// Used by every module under hw/rtl; depends on nothing else.
package pvf_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILE_LENGTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECTION_COUNT = 2'd3;

  // Input commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_XLATE = 1'b1;

  // Result error codes
  localparam logic [3:0] ERR_OK           = 4'd0;
  localparam logic [3:0] ERR_ZERO_SIZE    = 4'd1;
  localparam logic [3:0] ERR_SIZE_LIMIT   = 4'd2;
  localparam logic [3:0] ERR_BELOW_BASE   = 4'd3;
  localparam logic [3:0] ERR_RVA_OVERFLOW = 4'd4;
  localparam logic [3:0] ERR_AMBIGUOUS    = 4'd5;
  localparam logic [3:0] ERR_CROSSES      = 4'd6;
  localparam logic [3:0] ERR_FILE_BOUNDS  = 4'd7;
  localparam logic [3:0] ERR_UNMAPPED     = 4'd8;

  typedef struct packed {
    logic        command;
    logic [3:0]  entry_index;
    logic [31:0] entry_virtual_address;
    logic [31:0] entry_virtual_size;
    logic [31:0] entry_raw_size;
    logic [31:0] entry_raw_offset;
    logic [63:0] virt_addr;
    logic [31:0] window_size;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  error_code;
    logic [31:0] rel_addr;
    logic [31:0] offset_in_file;
    logic [3:0]  section_slot;
    logic        in_headers;
  } out_item_t;

  typedef struct packed {
    logic [63:0] image_base;
    logic [31:0] header_size;
    logic [31:0] file_length;
    logic [4:0]  section_count;
  } cfg_t;

  // One table entry as stored: the file-backed extent replaces both sizes
  typedef struct packed {
    logic [31:0] vaddr;
    logic [31:0] extent;
    logic [31:0] roffset;
  } sect_entry_t;

  // Shared compare unit: |a - b|, borrow, and magnitude below a limit
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] lim_fwd;
    logic [31:0] lim_bwd;
  } cmp_req_t;

  typedef struct packed {
    logic        borrow;
    logic [31:0] mag;
    logic        hit;
  } cmp_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE,
    S_SCAN,
    S_HDR,
    S_HFIT,
    S_XCHK,
    S_OVF,
    S_FIT,
    S_EMIT
  } seq_state_t;

endpackage

// File: hw/rtl/pvf_sect_table.sv
// Section table memory: one write port for loads, one registered read port.
// Depends on pvf_pkg (in_item_t, sect_entry_t).
module pvf_sect_table #(
  parameter int unsigned MAX_SECTIONS = 16,
  localparam int unsigned IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  pvf_pkg::in_item_t      ld_item,
  input  logic [IDX_W-1:0]       rd_addr,
  output pvf_pkg::sect_entry_t   rd_data
);

  pvf_pkg::sect_entry_t mem [MAX_SECTIONS];

  logic                 wr_ok;
  logic [IDX_W-1:0]     wr_addr;
  logic [31:0]          vsize_eff;
  pvf_pkg::sect_entry_t wr_entry;

  // Drop loads aimed past the table
  assign wr_ok   = wr_en && (32'(ld_item.entry_index) < MAX_SECTIONS);
  assign wr_addr = IDX_W'(ld_item.entry_index);

  // Fold the two sizes into the file-backed extent at load time
  always_comb begin
    vsize_eff = (ld_item.entry_virtual_size == 32'd0) ? ld_item.entry_raw_size
                                                       : ld_item.entry_virtual_size;
    wr_entry.vaddr   = ld_item.entry_virtual_address;
    wr_entry.extent  = (vsize_eff < ld_item.entry_raw_size) ? vsize_eff
                                                             : ld_item.entry_raw_size;
    wr_entry.roffset = ld_item.entry_raw_offset;
  end

  // Write the entry
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/pvf_cmp_unit.sv
// Shared 32-bit subtract/compare unit for the sequencer's scan and late checks.
// Depends on pvf_pkg (cmp_req_t, cmp_rsp_t).
module pvf_cmp_unit (
  input  pvf_pkg::cmp_req_t req,
  output pvf_pkg::cmp_rsp_t rsp
);

  logic [32:0] diff;
  logic [31:0] mag;

  // Subtract, then take the magnitude in the right direction
  assign diff = {1'b0, req.a} - {1'b0, req.b};
  assign mag  = diff[32] ? (req.b - req.a) : diff[31:0];

  // Compare the magnitude against the limit for its direction
  assign rsp.borrow = diff[32];
  assign rsp.mag    = mag;
  assign rsp.hit    = diff[32] ? (mag < req.lim_bwd) : (mag < req.lim_fwd);

endmodule

// File: hw/rtl/pvf_seq.sv
// Translate sequencer: early checks, one scan over the section table and the
// final window checks, the last two through the shared compare unit.
// Depends on pvf_pkg and pvf_cmp_unit.
module pvf_seq #(
  parameter int unsigned     MAX_SECTIONS = 16,
  parameter longint unsigned MAX_WINDOW   = 65536,
  localparam int unsigned IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [63:0]          start_va,
  input  logic [31:0]          start_size,
  input  pvf_pkg::cfg_t        cfg,
  output logic [IDX_W-1:0]     rd_addr,
  input  pvf_pkg::sect_entry_t rd_data,
  output logic                 busy,
  output logic                 res_valid,
  input  logic                 res_take,
  output pvf_pkg::out_item_t   res_item
);

  localparam int unsigned CNT_W = $clog2(MAX_SECTIONS + 1);

  pvf_pkg::seq_state_t state_r, state_nxt;

  logic [63:0]      va_r, va_nxt;
  logic [31:0]      size_r, size_nxt;
  logic [31:0]      rva_r, rva_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic             dv_r, dv_nxt;
  logic [IDX_W-1:0] ev_idx_r, ev_idx_nxt;
  logic             found_r, found_nxt;
  logic             ov_r, ov_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [31:0]      delta_r, delta_nxt;
  logic [31:0]      ext_r, ext_nxt;
  logic [31:0]      roff_r, roff_nxt;
  logic [31:0]      off_r, off_nxt;
  logic [3:0]       err_r, err_nxt;
  logic             hdr_r, hdr_nxt;

  pvf_pkg::cmp_req_t cmp_req;
  pvf_pkg::cmp_rsp_t cmp_rsp;

  logic [64:0] rva_full;
  logic        scan_issue;
  logic        scan_end;
  logic        scan_maps;
  logic        in_hdr;
  logic        chk_fail;
  logic [3:0]  chk_code;
  logic        res_ok;
  logic        res_early;

  pvf_cmp_unit u_cmp (
    .req (cmp_req),
    .rsp (cmp_rsp)
  );

  // Relative address of the request, with borrow for the below-base check
  assign rva_full = {1'b0, va_r} - {1'b0, cfg.image_base};

  assign scan_issue = (state_r == pvf_pkg::S_SCAN) && (i_r < cnt_r);
  assign scan_end   = (i_r == cnt_r);
  assign scan_maps  = dv_r && !cmp_rsp.borrow && cmp_rsp.hit;
  assign in_hdr     = !cmp_rsp.borrow && (cmp_rsp.mag != 32'd0);

  // Decide the failure of the current step
  always_comb begin
    chk_fail = 1'b0;
    chk_code = pvf_pkg::ERR_OK;
    case (state_r)
      pvf_pkg::S_PRE: begin
        chk_fail = 1'b1;
        if (size_r == 32'd0) begin
          chk_code = pvf_pkg::ERR_ZERO_SIZE;
        end else if (64'(size_r) > MAX_WINDOW) begin
          chk_code = pvf_pkg::ERR_SIZE_LIMIT;
        end else if (rva_full[64]) begin
          chk_code = pvf_pkg::ERR_BELOW_BASE;
        end else if (rva_full[63:32] != 32'd0) begin
          chk_code = pvf_pkg::ERR_RVA_OVERFLOW;
        end else begin
          chk_fail = 1'b0;
        end
      end
      pvf_pkg::S_SCAN: begin
        chk_fail = scan_maps && found_r;
        chk_code = pvf_pkg::ERR_AMBIGUOUS;
      end
      pvf_pkg::S_HDR: begin
        if (in_hdr) begin
          if (cmp_rsp.hit) begin
            chk_fail = 1'b1;
            chk_code = pvf_pkg::ERR_CROSSES;
          end else if (found_r || ov_r) begin
            chk_fail = 1'b1;
            chk_code = pvf_pkg::ERR_AMBIGUOUS;
          end
        end else if (!found_r) begin
          chk_fail = 1'b1;
          chk_code = pvf_pkg::ERR_UNMAPPED;
        end
      end
      pvf_pkg::S_HFIT, pvf_pkg::S_FIT: begin
        chk_fail = cmp_rsp.borrow || cmp_rsp.hit;
        chk_code = pvf_pkg::ERR_FILE_BOUNDS;
      end
      pvf_pkg::S_XCHK: begin
        if (cmp_rsp.hit) begin
          chk_fail = 1'b1;
          chk_code = pvf_pkg::ERR_CROSSES;
        end else if (ov_r) begin
          chk_fail = 1'b1;
          chk_code = pvf_pkg::ERR_AMBIGUOUS;
        end
      end
      pvf_pkg::S_OVF: begin
        chk_fail = cmp_rsp.borrow;
        chk_code = pvf_pkg::ERR_UNMAPPED;
      end
      default: begin
        chk_fail = 1'b0;
        chk_code = pvf_pkg::ERR_OK;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pvf_pkg::S_IDLE: if (start) state_nxt = pvf_pkg::S_PRE;
      pvf_pkg::S_PRE:  state_nxt = chk_fail ? pvf_pkg::S_EMIT : pvf_pkg::S_SCAN;
      pvf_pkg::S_SCAN: begin
        if (chk_fail) begin
          state_nxt = pvf_pkg::S_EMIT;
        end else if (scan_end) begin
          state_nxt = pvf_pkg::S_HDR;
        end
      end
      pvf_pkg::S_HDR: begin
        if (chk_fail) begin
          state_nxt = pvf_pkg::S_EMIT;
        end else if (in_hdr) begin
          state_nxt = pvf_pkg::S_HFIT;
        end else begin
          state_nxt = pvf_pkg::S_XCHK;
        end
      end
      pvf_pkg::S_HFIT: state_nxt = pvf_pkg::S_EMIT;
      pvf_pkg::S_XCHK: state_nxt = chk_fail ? pvf_pkg::S_EMIT : pvf_pkg::S_OVF;
      pvf_pkg::S_OVF:  state_nxt = chk_fail ? pvf_pkg::S_EMIT : pvf_pkg::S_FIT;
      pvf_pkg::S_FIT:  state_nxt = pvf_pkg::S_EMIT;
      pvf_pkg::S_EMIT: if (res_take) state_nxt = pvf_pkg::S_IDLE;
      default:         state_nxt = pvf_pkg::S_IDLE;
    endcase
  end

  // Outputs: handshake, table address and compare unit operands
  always_comb begin
    busy      = (state_r != pvf_pkg::S_IDLE);
    res_valid = (state_r == pvf_pkg::S_EMIT);
    rd_addr   = i_r[IDX_W-1:0];
    cmp_req   = '0;
    case (state_r)
      pvf_pkg::S_SCAN: begin
        cmp_req.a       = rva_r;
        cmp_req.b       = rd_data.vaddr;
        cmp_req.lim_fwd = rd_data.extent;
        cmp_req.lim_bwd = (rd_data.extent == 32'd0) ? 32'd0 : size_r;
      end
      pvf_pkg::S_HDR: begin
        cmp_req.a       = cfg.header_size;
        cmp_req.b       = rva_r;
        cmp_req.lim_fwd = size_r;
      end
      pvf_pkg::S_HFIT: begin
        cmp_req.a       = cfg.file_length;
        cmp_req.b       = rva_r;
        cmp_req.lim_fwd = size_r;
      end
      pvf_pkg::S_XCHK: begin
        cmp_req.a       = ext_r;
        cmp_req.b       = delta_r;
        cmp_req.lim_fwd = size_r;
      end
      pvf_pkg::S_OVF: begin
        cmp_req.a = ~delta_r;
        cmp_req.b = roff_r;
      end
      pvf_pkg::S_FIT: begin
        cmp_req.a       = cfg.file_length;
        cmp_req.b       = off_r;
        cmp_req.lim_fwd = size_r;
      end
      default: cmp_req = '0;
    endcase
  end

  // Datapath register updates
  always_comb begin
    va_nxt     = va_r;
    size_nxt   = size_r;
    rva_nxt    = rva_r;
    cnt_nxt    = cnt_r;
    i_nxt      = i_r;
    dv_nxt     = 1'b0;
    ev_idx_nxt = ev_idx_r;
    found_nxt  = found_r;
    ov_nxt     = ov_r;
    slot_nxt   = slot_r;
    delta_nxt  = delta_r;
    ext_nxt    = ext_r;
    roff_nxt   = roff_r;
    off_nxt    = off_r;
    err_nxt    = err_r;
    hdr_nxt    = hdr_r;
    case (state_r)
      pvf_pkg::S_IDLE: begin
        if (start) begin
          va_nxt   = start_va;
          size_nxt = start_size;
        end
      end
      pvf_pkg::S_PRE: begin
        rva_nxt   = rva_full[31:0];
        cnt_nxt   = (32'(cfg.section_count) > MAX_SECTIONS) ? CNT_W'(MAX_SECTIONS)
                                                             : CNT_W'(cfg.section_count);
        i_nxt     = '0;
        found_nxt = 1'b0;
        ov_nxt    = 1'b0;
        err_nxt   = chk_code;
      end
      pvf_pkg::S_SCAN: begin
        // Issue the next read while the previous entry is evaluated
        if (scan_issue) begin
          i_nxt      = i_r + CNT_W'(1);
          dv_nxt     = 1'b1;
          ev_idx_nxt = i_r[IDX_W-1:0];
        end
        if (scan_maps && !found_r) begin
          found_nxt = 1'b1;
          slot_nxt  = ev_idx_r;
          delta_nxt = cmp_rsp.mag;
          ext_nxt   = rd_data.extent;
          roff_nxt  = rd_data.roffset;
        end else if (dv_r && cmp_rsp.hit && cmp_rsp.borrow) begin
          ov_nxt = 1'b1;
        end
        err_nxt = chk_code;
      end
      pvf_pkg::S_HDR, pvf_pkg::S_XCHK: begin
        err_nxt = chk_code;
      end
      pvf_pkg::S_HFIT: begin
        err_nxt = chk_fail ? chk_code : pvf_pkg::ERR_OK;
        hdr_nxt = 1'b1;
        off_nxt = rva_r;
      end
      pvf_pkg::S_OVF: begin
        err_nxt = chk_code;
        off_nxt = roff_r + delta_r;
      end
      pvf_pkg::S_FIT: begin
        err_nxt = chk_fail ? chk_code : pvf_pkg::ERR_OK;
        hdr_nxt = 1'b0;
      end
      default: begin
        err_nxt = err_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pvf_pkg::S_IDLE;
      dv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dv_r    <= dv_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    va_r     <= va_nxt;
    size_r   <= size_nxt;
    rva_r    <= rva_nxt;
    cnt_r    <= cnt_nxt;
    i_r      <= i_nxt;
    ev_idx_r <= ev_idx_nxt;
    found_r  <= found_nxt;
    ov_r     <= ov_nxt;
    slot_r   <= slot_nxt;
    delta_r  <= delta_nxt;
    ext_r    <= ext_nxt;
    roff_r   <= roff_nxt;
    off_r    <= off_nxt;
    err_r    <= err_nxt;
    hdr_r    <= hdr_nxt;
  end

  // Assemble the result; error results carry no location
  always_comb begin
    res_ok    = (err_r == pvf_pkg::ERR_OK);
    res_early = err_r inside {pvf_pkg::ERR_ZERO_SIZE, pvf_pkg::ERR_SIZE_LIMIT,
                              pvf_pkg::ERR_BELOW_BASE, pvf_pkg::ERR_RVA_OVERFLOW};
    res_item.error_code     = err_r;
    res_item.rel_addr       = res_early ? 32'd0 : rva_r;
    res_item.offset_in_file = res_ok ? off_r : 32'd0;
    res_item.section_slot   = (res_ok && !hdr_r) ? 4'(slot_r) : 4'd0;
    res_item.in_headers     = res_ok && hdr_r;
  end

endmodule

// File: hw/rtl/pe_va_to_file_offset_translator_unit.sv
// Top level of the PE section address translator: configuration registers,
// result register and the section table. Depends on pvf_pkg, pvf_sect_table, pvf_seq.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): a load transaction
//   (command = load) writes one section entry and gives no
//   result; a translate transaction gives exactly one result transaction.
//   Result channel (out_valid / out_stall / out_data) is fed from a result
//   register, so a stalled receiver holds out_data stable.
//   Configuration port (cfg_we / cfg_index / cfg_wdata) writes image base,
//   header size, file length and section count; write only while idle.
//   Order of a translate: early checks first, which go straight to the result
//   on an error; otherwise a scan over the saturated section count reads one
//   table entry per cycle through the single registered read port and one
//   compare unit, followed by the header and window checks.
//   Throughput: one translate at a time; in_stall is high from acceptance
//   until the result moves into the result register, and stays low for loads.
//   Reset clears configuration to zero and empties the result register; the
//   section table keeps its contents and must be loaded before use.
module pe_va_to_file_offset_translator_unit #(
  parameter int unsigned     MAX_SECTIONS = 16,
  parameter longint unsigned MAX_WINDOW   = 65536
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pvf_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pvf_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [pvf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pvf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  pvf_pkg::cfg_t        cfg_r, cfg_nxt;
  logic                 out_valid_r, out_valid_nxt;
  pvf_pkg::out_item_t   out_data_r;

  logic                 busy;
  logic                 in_accept;
  logic                 ld_en;
  logic                 xl_start;
  logic [IDX_W-1:0]     rd_addr;
  pvf_pkg::sect_entry_t rd_data;
  logic                 res_valid;
  logic                 res_take;
  pvf_pkg::out_item_t   res_item;

  // Input handshake
  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;
  assign ld_en     = in_accept && (in_data.command == pvf_pkg::CMD_LOAD);
  assign xl_start  = in_accept && (in_data.command == pvf_pkg::CMD_XLATE);

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pvf_pkg::REG_IMAGE_BASE:    cfg_nxt.image_base    = cfg_wdata;
        pvf_pkg::REG_HEADER_SIZE:   cfg_nxt.header_size   = cfg_wdata[31:0];
        pvf_pkg::REG_FILE_LENGTH:   cfg_nxt.file_length   = cfg_wdata[31:0];
        pvf_pkg::REG_SECTION_COUNT: cfg_nxt.section_count = cfg_wdata[4:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pvf_sect_table #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ld_en),
    .ld_item (in_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pvf_seq #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .MAX_WINDOW   (MAX_WINDOW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (xl_start),
    .start_va   (in_data.virt_addr),
    .start_size (in_data.window_size),
    .cfg        (cfg_r),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .busy       (busy),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res_item   (res_item)
  );

  // Result register: take a new result when empty or being drained
  assign res_take      = res_valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = res_take || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/pvf_checker.sv
// Port-level assertions for the PE section address translator, bound to the top.
// Depends on pvf_pkg and pe_va_to_file_offset_translator_unit.
module pvf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input pvf_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input pvf_pkg::out_item_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Block further transactions while a translate is in flight
  a_busy_after_xlate: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.command == pvf_pkg::CMD_XLATE) |=> in_stall)
    else $error("translate accepted without going busy");

  // Carry no location on an error result
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.error_code != pvf_pkg::ERR_OK) |->
      (out_data.offset_in_file == 32'd0) && (out_data.section_slot == 4'd0) &&
      !out_data.in_headers)
    else $error("error result carries a location");

  // Map a header window onto itself
  a_hdr_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.in_headers |->
      (out_data.error_code == pvf_pkg::ERR_OK) &&
      (out_data.offset_in_file == out_data.rel_addr) && (out_data.section_slot == 4'd0))
    else $error("header result inconsistent");

  // Report no relative address for the early checks
  a_early_rel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.error_code == pvf_pkg::ERR_ZERO_SIZE) ||
                  (out_data.error_code == pvf_pkg::ERR_SIZE_LIMIT) ||
                  (out_data.error_code == pvf_pkg::ERR_BELOW_BASE) ||
                  (out_data.error_code == pvf_pkg::ERR_RVA_OVERFLOW)) |->
      out_data.rel_addr == 32'd0)
    else $error("early error with nonzero relative address");

endmodule

bind pe_va_to_file_offset_translator_unit pvf_checker u_pvf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
